// File: src/lage_pkg.sv
// Shared types, sizes and codes for the life automaton grid engine.
// Used by every module of the block; depends on nothing else.
package lage_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int CFG_W     = 7;
  localparam int ROW_LIM_W = (ROW_CNT_W > CFG_W) ? ROW_CNT_W : CFG_W;
  localparam int COL_LIM_W = (COL_CNT_W > CFG_W) ? COL_CNT_W : CFG_W;
  localparam int GEN_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int NBR_W     = 4;

  localparam logic [CFG_W-1:0] RESET_SIZE = CFG_W'(16);

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t  req_type;
    logic [5:0] row;
    logic [5:0] col;
    logic       alive_in;
  } req_t;

  typedef struct packed {
    logic             alive_out;
    logic [GEN_W-1:0] generation;
    logic             out_of_range;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic             clear;
  } mem_cmd_t;

endpackage

// File: src/lage_row_mem.sv
// Row-wide cell memory with one read and one write port and registered read data.
// Per-row valid bits let a clear empty every row at once; depends on lage_pkg.
module lage_row_mem (
  input  logic                      clk,
  input  logic                      rst,
  input  lage_pkg::mem_cmd_t        cmd,
  input  logic [lage_pkg::MAX_COLS-1:0] wr_data,
  output logic [lage_pkg::MAX_COLS-1:0] rd_data
);
  import lage_pkg::*;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid;
  logic [MAX_COLS-1:0] rd_word;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_row] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_word <= mem[cmd.rd_row];
    end
  end

  // A row that has not been written since the last clear reads as all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_valid <= row_valid[cmd.rd_row];
      end
      if (cmd.clear) begin
        row_valid <= '0;
      end else if (cmd.wr_en) begin
        row_valid[cmd.wr_row] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// File: src/lage_next_row.sv
// Applies rule B3/S23 to one whole row in parallel, one lane per column.
// Takes the rows above, at and below; depends on lage_pkg.
module lage_next_row (
  input  logic [lage_pkg::MAX_COLS-1:0]  above,
  input  logic [lage_pkg::MAX_COLS-1:0]  mid,
  input  logic [lage_pkg::MAX_COLS-1:0]  below,
  input  logic [lage_pkg::COL_LIM_W-1:0] used_cols,
  output logic [lage_pkg::MAX_COLS-1:0]  new_row
);
  import lage_pkg::*;

  // Shifted copies put each lane's left and right neighbours in place; the
  // bit shifted in at either edge stands for a dead cell beyond the grid.
  logic [MAX_COLS-1:0] above_l, above_r, mid_l, mid_r, below_l, below_r;

  assign above_l = above << 1;
  assign above_r = above >> 1;
  assign mid_l   = mid << 1;
  assign mid_r   = mid >> 1;
  assign below_l = below << 1;
  assign below_r = below >> 1;

  always_comb begin
    logic [NBR_W-1:0] n;
    n = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      n = NBR_W'(above_l[c]) + NBR_W'(above[c]) + NBR_W'(above_r[c])
        + NBR_W'(mid_l[c]) + NBR_W'(mid_r[c])
        + NBR_W'(below_l[c]) + NBR_W'(below[c]) + NBR_W'(below_r[c]);
      new_row[c] = (COL_LIM_W'(c) < used_cols)
                   && ((n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && mid[c]));
    end
  end

endmodule

// File: src/life_automaton_grid_engine_unit.sv
// Top level of the life automaton grid engine: request handshake, sequencer,
// generation counter and size registers. Depends on lage_pkg, lage_row_mem, lage_next_row.
//
//   channel    handshake              payload
//   ---------  ---------------------  ----------------------------------
//   request    req_valid / req_stall  req  (lage_pkg::req_t)
//   response   rsp_valid / rsp_stall  rsp  (lage_pkg::rsp_t)
//   config     cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An in-grid read or write goes through ST_CELL to ST_DONE, where its response is
// loaded; a clear or an out-of-range access goes straight to ST_DONE; an advance first
// sweeps the rows in use (skipped if none are in use). A new request is taken once the
// previous response is loaded. Reset (rst, synchronous) empties the grid at once through
// per-row valid bits, zeroes the counter and sets both sizes to 16. A stalled response
// holds in the output register while the engine goes back to taking requests.
module life_automaton_grid_engine_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  lage_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output lage_pkg::rsp_t                     rsp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lage_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lage_pkg::CFG_W-1:0]         cfg_data
);
  import lage_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]     grid_rows, grid_cols;
  logic [ROW_LIM_W-1:0] used_rows;
  logic [COL_LIM_W-1:0] used_cols;
  logic [GEN_W-1:0]     generation, gen_inc;

  req_t                 cur_req;
  logic [ROW_CNT_W-1:0] idx, idx_inc, idx_dec;
  logic [ROW_LIM_W-1:0] idx_ext;
  logic [MAX_COLS-1:0]  prev_row, cur_row, below_row, new_row, rd_data, wr_data;
  rsp_t                 pend;

  logic                 req_fire, rsp_free, cfg_fire, cfg_hit, req_in_grid, adv_last;
  logic [ROW_LIM_W-1:0] req_row_ext, cur_row_ext;
  logic [COL_LIM_W-1:0] req_col_ext, cur_col_ext;
  logic [ROW_W-1:0]     req_row_addr, cur_row_addr;
  logic [COL_W-1:0]     cur_col_addr;
  mem_cmd_t             mem_cmd;

  // Sizes above the memory's extent act as the full extent.
  assign used_rows = (ROW_LIM_W'(grid_rows) > ROW_LIM_W'(MAX_ROWS))
                     ? ROW_LIM_W'(MAX_ROWS) : ROW_LIM_W'(grid_rows);
  assign used_cols = (COL_LIM_W'(grid_cols) > COL_LIM_W'(MAX_COLS))
                     ? COL_LIM_W'(MAX_COLS) : COL_LIM_W'(grid_cols);

  assign req_fire  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && ((cfg_index == REG_GRID_ROWS) || (cfg_index == REG_GRID_COLS));
  assign gen_inc   = generation + GEN_W'(1);

  assign req_row_ext  = ROW_LIM_W'(req.row);
  assign req_col_ext  = COL_LIM_W'(req.col);
  assign req_row_addr = req_row_ext[ROW_W-1:0];
  assign req_in_grid  = (req_row_ext < used_rows) && (req_col_ext < used_cols);
  assign cur_row_ext  = ROW_LIM_W'(cur_req.row);
  assign cur_col_ext  = COL_LIM_W'(cur_req.col);
  assign cur_row_addr = cur_row_ext[ROW_W-1:0];
  assign cur_col_addr = cur_col_ext[COL_W-1:0];

  // The advance sweep: at step idx the memory returns row idx, so row idx-1
  // can be finished from the held rows and written back. Row idx-1 is never
  // read again, so the write cannot disturb a later read of the sweep.
  assign idx_ext   = ROW_LIM_W'(idx);
  assign idx_inc   = idx + ROW_CNT_W'(1);
  assign idx_dec   = idx - ROW_CNT_W'(1);
  assign adv_last  = (idx_ext == used_rows);
  assign below_row = (idx_ext < used_rows) ? rd_data : '0;

  lage_row_mem u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mem_cmd),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  lage_next_row u_next_row (
    .above     (prev_row),
    .mid       (cur_row),
    .below     (below_row),
    .used_cols (used_cols),
    .new_row   (new_row)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.req_type) inside
            REQ_WRITE, REQ_READ: state_next = req_in_grid ? ST_CELL : ST_DONE;
            REQ_ADVANCE:         state_next = (used_rows == '0) ? ST_DONE : ST_ADV_RUN;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_CELL: state_next = ST_DONE;
      ST_ADV_RUN: begin
        if (adv_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory commands and handshake outputs.
  always_comb begin
    logic [MAX_COLS-1:0] patched;
    patched   = rd_data;
    patched[cur_col_addr] = cur_req.alive_in;
    mem_cmd   = '0;
    wr_data   = new_row;
    req_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.req_type) inside
            REQ_WRITE, REQ_READ: begin
              mem_cmd.rd_en  = req_in_grid;
              mem_cmd.rd_row = req_row_addr;
            end
            REQ_ADVANCE: begin
              mem_cmd.rd_en  = 1'b1;
              mem_cmd.rd_row = '0;
            end
            default: mem_cmd.clear = 1'b1;
          endcase
        end
      end
      ST_CELL: begin
        mem_cmd.wr_en  = (cur_req.req_type == REQ_WRITE);
        mem_cmd.wr_row = cur_row_addr;
        wr_data        = patched;
      end
      ST_ADV_RUN: begin
        mem_cmd.wr_en  = (idx != '0);
        mem_cmd.wr_row = idx_dec[ROW_W-1:0];
        mem_cmd.rd_en  = !adv_last;
        mem_cmd.rd_row = idx_inc[ROW_W-1:0];
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
    if (cfg_hit) begin
      mem_cmd.clear = 1'b1;
    end
  end

  // Control state: sequencer, response valid, counter and size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      generation <= '0;
      grid_rows  <= RESET_SIZE;
      grid_cols  <= RESET_SIZE;
    end else begin
      state <= state_next;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end
      if (state == ST_IDLE && req_fire) begin
        if (req.req_type == REQ_CLEAR) begin
          generation <= '0;
        end else if (req.req_type == REQ_ADVANCE && used_rows == '0) begin
          generation <= gen_inc;
        end
      end
      if (state == ST_ADV_RUN && adv_last) begin
        generation <= gen_inc;
      end
      // Resizing empties the grid and restarts the count.
      if (cfg_hit) begin
        generation <= '0;
        if (cfg_index == REG_GRID_ROWS) begin
          grid_rows <= cfg_data;
        end else begin
          grid_cols <= cfg_data;
        end
      end
    end
  end

  // Payload registers: captured request, sweep rows, pending and shown response.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          cur_req               <= req;
          idx                   <= '0;
          prev_row              <= '0;
          cur_row               <= '0;
          pend.alive_out        <= 1'b0;
          pend.out_of_range     <= 1'b0;
          pend.generation       <= generation;
          case (req.req_type) inside
            REQ_WRITE, REQ_READ: pend.out_of_range <= !req_in_grid;
            REQ_ADVANCE:         pend.generation   <= gen_inc;
            default:             pend.generation   <= '0;
          endcase
        end
      end
      ST_CELL: begin
        pend.alive_out    <= (cur_req.req_type == REQ_READ) && rd_data[cur_col_addr];
        pend.generation   <= generation;
        pend.out_of_range <= 1'b0;
      end
      ST_ADV_RUN: begin
        prev_row <= cur_row;
        cur_row  <= below_row;
        idx      <= idx_inc;
        if (adv_last) begin
          pend.alive_out    <= 1'b0;
          pend.generation   <= gen_inc;
          pend.out_of_range <= 1'b0;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp <= pend;
        end
      end
      default: begin
      end
    endcase
  end

  // The sweep never reads the row it is writing back in the same cycle.
  a_no_rw_same_row: assert property (@(posedge clk) disable iff (rst)
    (mem_cmd.rd_en && mem_cmd.wr_en) |-> (mem_cmd.rd_row != mem_cmd.wr_row))
    else $error("row memory read and written at the same row");

  // Finishing an advance sweep bumps the counter by exactly one.
  a_adv_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV_RUN && adv_last && !cfg_hit)
      |=> (generation == $past(gen_inc)))
    else $error("advance did not increment the generation counter");

  // A response only appears after the sequencer has finished a request.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_DONE))
    else $error("response raised outside the completion step");

endmodule

// File: tb/sv/life_automaton_grid_engine_unit_tb.sv
// Self-checking testbench for life_automaton_grid_engine_unit: a built-in predictor of
// the B3/S23 grid and its generation counter checks every response in order.
// Depends on lage_pkg and the RTL of the engine only.
module life_automaton_grid_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lage_pkg::*;

  // Cycles without any handshake before the run is abandoned. The longest honest
  // quiet stretch is the receiver hold below plus one full-grid advance.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the deliberate receiver hold used to back the engine up.
  localparam int HOLD_CYCLES = 300;

  // Register indexes that the engine decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predicted state of the engine: the cell grid, the two size registers and the
  // generation counter. It is updated at the edge where each request is accepted.
  bit [MAX_COLS-1:0] life_grid [MAX_ROWS];
  logic [CFG_W-1:0]  rows_reg = RESET_SIZE;
  logic [CFG_W-1:0]  cols_reg = RESET_SIZE;
  logic [GEN_W-1:0]  gen_count = '0;

  // Responses still owed by the engine, oldest first.
  rsp_t       pending_rsps [$];
  reg_write_t queued_writes [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_len = 0;
  bit idling_on = 1'b1;
  rsp_t want;

  life_automaton_grid_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A size register above the grid limit behaves as the limit itself.
  function automatic int rows_in_use();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic int cols_in_use();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic void wipe_grid();
    foreach (life_grid[i]) life_grid[i] = '0;
    gen_count = '0;
  endfunction

  // Applies one request to the predicted state and returns the response the
  // engine owes for it.
  function automatic rsp_t predict_response(req_t item);
    rsp_t              res;
    bit [MAX_COLS-1:0] next_grid [MAX_ROWS];
    int                nr, nc, n, r, c, dr, dc;
    nr  = rows_in_use();
    nc  = cols_in_use();
    res = '0;
    case (item.req_type)
      REQ_WRITE, REQ_READ: begin
        if (int'(item.row) >= nr || int'(item.col) >= nc) begin
          res.out_of_range = 1'b1;
        end else if (item.req_type == REQ_WRITE) begin
          life_grid[item.row][item.col] = item.alive_in;
        end else begin
          res.alive_out = life_grid[item.row][item.col];
        end
      end
      REQ_ADVANCE: begin
        // Every new cell is taken from the old generation; anything beyond
        // the grid in use counts as dead, with no wraparound.
        foreach (next_grid[i]) next_grid[i] = '0;
        for (r = 0; r < nr; r++) begin
          for (c = 0; c < nc; c++) begin
            n = 0;
            for (dr = -1; dr <= 1; dr++) begin
              for (dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr &&
                    c + dc >= 0 && c + dc < nc) begin
                  n += life_grid[r + dr][c + dc];
                end
              end
            end
            next_grid[r][c] = (n == BIRTH_COUNT) ||
                              (n == SURVIVE_COUNT && life_grid[r][c]);
          end
        end
        life_grid = next_grid;
        gen_count = gen_count + GEN_W'(1);
      end
      REQ_CLEAR: begin
        wipe_grid();
      end
    endcase
    res.generation = gen_count;
    return res;
  endfunction

  function automatic req_t make_req(req_kind_t kind, int r, int c, bit v);
    req_t item;
    item.req_type = kind;
    item.row      = 6'(r);
    item.col      = 6'(c);
    item.alive_in = v;
    return item;
  endfunction

  // Random request. While seeding, the mix leans to writes so that the grid
  // fills up before advances start; positions are mostly inside the grid, with
  // an occasional one anywhere in the field range.
  function automatic req_t random_request(bit seeding);
    req_kind_t kind;
    int        pick, nr, nc, r, c;
    nr   = rows_in_use();
    nc   = cols_in_use();
    pick = $urandom_range(0, 99);
    if (seeding) begin
      kind = (pick < 85) ? REQ_WRITE : REQ_READ;
    end else if (pick < 30) begin
      kind = REQ_WRITE;
    end else if (pick < 65) begin
      kind = REQ_READ;
    end else if (pick < 95) begin
      kind = REQ_ADVANCE;
    end else begin
      kind = REQ_CLEAR;
    end
    if (nr == 0 || nc == 0 || $urandom_range(0, 7) == 0) begin
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
    end else begin
      r = $urandom_range(0, nr - 1);
      c = $urandom_range(0, nc - 1);
    end
    return make_req(kind, r, c, 1'($urandom_range(0, 1)));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  // Offers one request, with an optional gap first, and holds it until the
  // engine takes it. Valid stays high afterwards so that back-to-back requests
  // need no dead cycle.
  task automatic send_request(req_t item);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    pending_rsps.push_back(predict_response(item));
  endtask

  // Stops offering requests and waits until every owed response has arrived.
  task automatic wait_until_drained();
    req_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
  endtask

  // Sends the queued register writes once the engine is idle, keeping valid
  // high across them.
  task automatic apply_register_writes();
    reg_write_t w;
    wait_until_drained();
    while (queued_writes.size() != 0) begin
      w = queued_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      // Writing either size register empties the grid and zeroes the counter.
      if (w.idx == REG_GRID_ROWS) begin
        rows_reg = w.data;
        wipe_grid();
      end else if (w.idx == REG_GRID_COLS) begin
        cols_reg = w.data;
        wipe_grid();
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid_size(int rows, int cols);
    queued_writes.push_back('{idx: REG_GRID_ROWS, data: CFG_W'(rows)});
    queued_writes.push_back('{idx: REG_GRID_COLS, data: CFG_W'(cols)});
    apply_register_writes();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset the grid is 16 by 16, empty, and the counter is zero.
  task automatic test_reset_defaults();
    send_request(make_req(REQ_READ, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 16, 0, 1'b0));
    send_request(make_req(REQ_READ, 0, 16, 1'b0));
    send_request(make_req(REQ_WRITE, 63, 63, 1'b1));
  endtask

  // Writes and reads at the corners, then writes to the spare register
  // indexes, which must leave the grid alone.
  task automatic test_cell_access();
    send_request(make_req(REQ_WRITE, 0, 0, 1'b1));
    send_request(make_req(REQ_WRITE, 15, 15, 1'b1));
    send_request(make_req(REQ_READ, 0, 0, 1'b0));
    send_request(make_req(REQ_WRITE, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 0, 0, 1'b1));
    queued_writes.push_back('{idx: REG_SPARE_A, data: '1});
    queued_writes.push_back('{idx: REG_SPARE_B, data: '0});
    apply_register_writes();
    send_request(make_req(REQ_READ, 15, 15, 1'b0));
  endtask

  // A blinker across the middle row of a 3 by 3 grid: births, survival and death
  // all occur with the outside counting as dead. A clear and a read then end the test.
  task automatic test_rule_at_edges();
    set_grid_size(3, 3);
    send_request(make_req(REQ_WRITE, 1, 0, 1'b1));
    send_request(make_req(REQ_WRITE, 1, 1, 1'b1));
    send_request(make_req(REQ_WRITE, 1, 2, 1'b1));
    send_request(make_req(REQ_ADVANCE, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 0, 1, 1'b0));
    send_request(make_req(REQ_READ, 1, 0, 1'b0));
    send_request(make_req(REQ_CLEAR, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 1, 1, 1'b0));
  endtask

  // An empty grid makes every access out of range yet still counts advances;
  // a single cell dies alone; sizes above the limit act as the full grid.
  task automatic test_size_extremes();
    set_grid_size(0, 0);
    send_request(make_req(REQ_WRITE, 0, 0, 1'b1));
    send_request(make_req(REQ_ADVANCE, 0, 0, 1'b0));
    set_grid_size(1, 1);
    send_request(make_req(REQ_WRITE, 0, 0, 1'b1));
    send_request(make_req(REQ_ADVANCE, 0, 0, 1'b0));
    send_request(make_req(REQ_READ, 0, 0, 1'b0));
    set_grid_size(127, 127);
    send_request(make_req(REQ_WRITE, 63, 63, 1'b1));
    send_request(make_req(REQ_READ, 63, 63, 1'b0));
  endtask

  // Several grid sizes, each seeded with random writes before a mix of
  // advances, reads, writes and the odd clear.
  task automatic test_random_phases();
    int phase, k;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_grid_size(64, 64);
        1: set_grid_size($urandom_range(0, 127), $urandom_range(0, 127));
        2: set_grid_size(127, $urandom_range(3, 8));
        default: set_grid_size($urandom_range(3, 8), $urandom_range(3, 8));
      endcase
      for (k = 0; k < 17; k++) send_request(random_request(k < 10));
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the engine backs up and stalls its request side.
  task automatic test_receiver_hold();
    int k;
    set_grid_size($urandom_range(4, 10), $urandom_range(4, 10));
    hold_len = HOLD_CYCLES;
    for (k = 0; k < 12; k++) send_request(random_request(k < 5));
  endtask

  // Full rate on both sides to close the run.
  task automatic test_no_idling();
    int k;
    idling_on = 1'b0;
    set_grid_size(64, $urandom_range(1, 64));
    for (k = 0; k < 20; k++) send_request(random_request(k < 8));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // The response stall comes either as a requested long hold or as random
  // bursts while idling is enabled.
  always begin
    @(posedge clk);
    if (hold_len > 0) begin
      rsp_stall <= 1'b1;
      repeat (hold_len) @(posedge clk);
      hold_len = 0;
      rsp_stall <= 1'b0;
    end else if (idling_on && !rst && $urandom_range(0, 5) == 0) begin
      rsp_stall <= 1'b1;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      rsp_stall <= 1'b0;
    end
  end

  function automatic void report_field(string field, longint unsigned exp_val,
                                       longint unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Every accepted response is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsps.size() == 0) begin
        $display("%0t: response with nothing expected, expected none, actual %p",
                 $time, rsp);
        mismatches++;
      end else begin
        want = pending_rsps.pop_front();
        report_field("alive_out", 64'(want.alive_out), 64'(rsp.alive_out));
        report_field("generation", 64'(want.generation), 64'(rsp.generation));
        report_field("out_of_range", 64'(want.out_of_range), 64'(rsp.out_of_range));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (!rst && rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d responses owed", $time,
               pending_rsps.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    wipe_grid();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_cell_access();
    test_rule_at_edges();
    test_size_extremes();
    test_random_phases();
    test_receiver_hold();
    test_no_idling();
    wait_until_drained();
    // Allow time for any stray response that should not be there.
    repeat (MAX_ROWS + 16) @(posedge clk);
    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
